[rtl/core/cbf_pkg.sv]
// Shared types, widths and helper functions for the cubic Bezier flattener.
// Used by every module of the core; depends on nothing else.
`default_nettype none

package cbf_pkg;

	localparam int MAX_DEPTH_DEF = 6;
	localparam int COORD_W       = 20;
	localparam int COEF_W        = 25;
	localparam int DEPTH_W       = 3;
	localparam int DELTA_W       = 23;
	localparam int OCTA_W        = 24;
	localparam int WHOLE_W       = 19;
	localparam int LG_W          = 5;
	localparam int QUEUE_DEPTH   = 2;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_start;
		logic signed [COORD_W-1:0] y_start;
		logic signed [COORD_W-1:0] x_ctrl_a;
		logic signed [COORD_W-1:0] y_ctrl_a;
		logic signed [COORD_W-1:0] x_ctrl_b;
		logic signed [COORD_W-1:0] y_ctrl_b;
		logic signed [COORD_W-1:0] x_end;
		logic signed [COORD_W-1:0] y_end;
	} curve_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pt_x;
		logic signed [COORD_W-1:0] pt_y;
		logic                      last;
	} vertex_t;

	// Polynomial form of one curve: P(t) = a t^3 + b t^2 + c t + p0
	typedef struct packed {
		logic signed [COORD_W-1:0] x0;
		logic signed [COORD_W-1:0] y0;
		logic signed [COEF_W-1:0]  ax;
		logic signed [COEF_W-1:0]  bx;
		logic signed [COEF_W-1:0]  cx;
		logic signed [COEF_W-1:0]  ay;
		logic signed [COEF_W-1:0]  by;
		logic signed [COEF_W-1:0]  cy;
		logic [DEPTH_W-1:0]        depth;
	} job_t;

	// 2*max + min of the magnitudes
	function automatic logic [OCTA_W-1:0] octa(input logic signed [DELTA_W-1:0] dx,
			input logic signed [DELTA_W-1:0] dy);
		logic signed [OCTA_W-1:0] ex;
		logic signed [OCTA_W-1:0] ey;
		logic [OCTA_W-1:0]        mx;
		logic [OCTA_W-1:0]        my;
		ex = OCTA_W'(dx);
		ey = OCTA_W'(dy);
		mx = ex[OCTA_W-1] ? OCTA_W'(-ex) : OCTA_W'(ex);
		my = ey[OCTA_W-1] ? OCTA_W'(-ey) : OCTA_W'(ey);
		if (mx > my)
			return OCTA_W'({mx, 1'b0} + {1'b0, my});
		else
			return OCTA_W'({my, 1'b0} + {1'b0, mx});
	endfunction

	// Index of the highest set bit, zero for 0 and 1
	function automatic logic [LG_W-1:0] floor_log2(input logic [WHOLE_W-1:0] v);
		logic [LG_W-1:0] lg;
		lg = '0;
		for (int i = 1; i < WHOLE_W; i++)
			if (v[i])
				lg = LG_W'(i);
		return lg;
	endfunction

endpackage

`default_nettype wire

[rtl/core/cbf_front.sv]
// Front end: takes curves, measures the bulge, picks the split depth and
// forms the polynomial coefficients. Uses cbf_pkg.
`default_nettype none

module cbf_front #(
	parameter int MAX_DEPTH = cbf_pkg::MAX_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire cbf_pkg::curve_t curve,
	output logic                q_wr,
	output cbf_pkg::job_t       q_job,
	input  wire logic           q_full
);

	cbf_pkg::curve_t                   curve_s1;
	logic                              v_s1_q;
	logic                              v_s2_q;
	logic [cbf_pkg::OCTA_W-1:0]        dist1_s2;
	logic [cbf_pkg::OCTA_W-1:0]        dist2_s2;
	cbf_pkg::job_t                     job_s2;

	logic                              accept;
	logic                              adv2;
	logic                              mv1;

	logic signed [cbf_pkg::COORD_W:0]   sx;
	logic signed [cbf_pkg::COORD_W:0]   sy;
	logic signed [cbf_pkg::DELTA_W-1:0] dx1, dy1, dx2, dy2;
	cbf_pkg::job_t                     job_c;

	logic [cbf_pkg::OCTA_W-1:0]        dmax;
	logic [cbf_pkg::OCTA_W:0]          dround;
	logic [cbf_pkg::WHOLE_W-1:0]       whole;
	logic [cbf_pkg::LG_W-1:0]          lg;
	logic [cbf_pkg::LG_W-1:0]          dep;

	assign adv2   = v_s2_q && !q_full;
	assign mv1    = v_s1_q && (!v_s2_q || adv2);
	assign full   = v_s1_q && !mv1;
	assign accept = push && !full;

	// Stage 1: distances to the chord midpoint and coefficients
	always_comb begin
		sx  = (cbf_pkg::COORD_W+1)'(curve_s1.x_start) + (cbf_pkg::COORD_W+1)'(curve_s1.x_end);
		sy  = (cbf_pkg::COORD_W+1)'(curve_s1.y_start) + (cbf_pkg::COORD_W+1)'(curve_s1.y_end);
		dx1 = cbf_pkg::DELTA_W'(sx) - (cbf_pkg::DELTA_W'(curve_s1.x_ctrl_a) <<< 1);
		dy1 = cbf_pkg::DELTA_W'(sy) - (cbf_pkg::DELTA_W'(curve_s1.y_ctrl_a) <<< 1);
		dx2 = cbf_pkg::DELTA_W'(sx) - (cbf_pkg::DELTA_W'(curve_s1.x_ctrl_b) <<< 1);
		dy2 = cbf_pkg::DELTA_W'(sy) - (cbf_pkg::DELTA_W'(curve_s1.y_ctrl_b) <<< 1);

		job_c       = '0;
		job_c.x0    = curve_s1.x_start;
		job_c.y0    = curve_s1.y_start;
		job_c.ax    = cbf_pkg::COEF_W'((cbf_pkg::COEF_W'(curve_s1.x_end)
			- cbf_pkg::COEF_W'(curve_s1.x_start))
			+ 3 * (cbf_pkg::COEF_W'(curve_s1.x_ctrl_a) - cbf_pkg::COEF_W'(curve_s1.x_ctrl_b)));
		job_c.ay    = cbf_pkg::COEF_W'((cbf_pkg::COEF_W'(curve_s1.y_end)
			- cbf_pkg::COEF_W'(curve_s1.y_start))
			+ 3 * (cbf_pkg::COEF_W'(curve_s1.y_ctrl_a) - cbf_pkg::COEF_W'(curve_s1.y_ctrl_b)));
		job_c.bx    = cbf_pkg::COEF_W'(3 * (cbf_pkg::COEF_W'(curve_s1.x_start)
			- (cbf_pkg::COEF_W'(curve_s1.x_ctrl_a) <<< 1) + cbf_pkg::COEF_W'(curve_s1.x_ctrl_b)));
		job_c.by    = cbf_pkg::COEF_W'(3 * (cbf_pkg::COEF_W'(curve_s1.y_start)
			- (cbf_pkg::COEF_W'(curve_s1.y_ctrl_a) <<< 1) + cbf_pkg::COEF_W'(curve_s1.y_ctrl_b)));
		job_c.cx    = cbf_pkg::COEF_W'(3 * (cbf_pkg::COEF_W'(curve_s1.x_ctrl_a)
			- cbf_pkg::COEF_W'(curve_s1.x_start)));
		job_c.cy    = cbf_pkg::COEF_W'(3 * (cbf_pkg::COEF_W'(curve_s1.y_ctrl_a)
			- cbf_pkg::COEF_W'(curve_s1.y_start)));
	end

	// Stage 2: round to whole pixels and turn the log into a depth
	always_comb begin
		dmax   = (dist1_s2 > dist2_s2) ? dist1_s2 : dist2_s2;
		dround = {1'b0, dmax} + (cbf_pkg::OCTA_W+1)'(63);
		whole  = dround[cbf_pkg::OCTA_W -: cbf_pkg::WHOLE_W];
		lg     = cbf_pkg::floor_log2(whole);
		dep    = {1'b0, lg[cbf_pkg::LG_W-1:1]} + cbf_pkg::LG_W'(1);
		if (dep > cbf_pkg::LG_W'(MAX_DEPTH))
			dep = cbf_pkg::LG_W'(MAX_DEPTH);
		q_job       = job_s2;
		q_job.depth = cbf_pkg::DEPTH_W'(dep);
	end

	assign q_wr = adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
		end else begin
			if (accept)
				v_s1_q <= 1'b1;
			else if (mv1)
				v_s1_q <= 1'b0;
			if (mv1)
				v_s2_q <= 1'b1;
			else if (adv2)
				v_s2_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			curve_s1 <= curve;
		if (mv1) begin
			dist1_s2 <= cbf_pkg::octa(dx1, dy1);
			dist2_s2 <= cbf_pkg::octa(dx2, dy2);
			job_s2   <= job_c;
		end
	end

endmodule

`default_nettype wire

[rtl/core/cbf_queue.sv]
// Short job queue between front and back end, held in flip-flops.
// Uses cbf_pkg for the job type.
`default_nettype none

module cbf_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr,
	input  wire cbf_pkg::job_t wr_job,
	output logic               full,
	input  wire logic          rd,
	output cbf_pkg::job_t      rd_job,
	output logic               valid
);

	localparam int PTR_W = (cbf_pkg::QUEUE_DEPTH > 1) ? $clog2(cbf_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(cbf_pkg::QUEUE_DEPTH + 1);

	cbf_pkg::job_t     slot_q [cbf_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full   = (count_q == CNT_W'(cbf_pkg::QUEUE_DEPTH));
	assign valid  = (count_q != '0);
	assign rd_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(cbf_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + PTR_W'(1);
			if (rd)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(cbf_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + PTR_W'(1);
			if (wr && !rd)
				count_q <= count_q + CNT_W'(1);
			else if (rd && !wr)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			slot_q[wr_ptr_q] <= wr_job;
	end

endmodule

`default_nettype wire

[rtl/core/cbf_back.sv]
// Back end: walks the 2^depth leaf end points of one curve by exact forward
// differencing and holds each vertex in the output register. Uses cbf_pkg.
`default_nettype none

module cbf_back #(
	parameter int MAX_DEPTH = cbf_pkg::MAX_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  wire cbf_pkg::job_t q_job,
	output logic               q_rd,
	output logic               empty,
	input  wire logic          pop,
	output cbf_pkg::vertex_t   vertex
);

	// Points are scaled by 2^(3*depth); a few guard bits cover the differences
	localparam int SW    = cbf_pkg::COORD_W + 3 * MAX_DEPTH + 4;
	localparam int SH_W  = $clog2(3 * MAX_DEPTH + 2);
	localparam int CNT_W = MAX_DEPTH + 1;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic                  state_q;
	logic signed [SW-1:0]  px_q, d1x_q, d2x_q, d3x_q;
	logic signed [SW-1:0]  py_q, d1y_q, d2y_q, d3y_q;
	logic [SH_W-1:0]       sh3_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      last_idx_q;
	logic                  out_valid_q;
	cbf_pkg::vertex_t      out_q;

	logic                  slot_free;
	logic                  load;
	logic                  step;
	logic                  at_last;
	logic [SH_W-1:0]       sh1, sh2, sh3;
	logic signed [SW-1:0]  px_n, py_n;
	logic signed [SW-1:0]  a6x, a6y;
	logic signed [SW-1:0]  px_i, d1x_i, d2x_i;
	logic signed [SW-1:0]  py_i, d1y_i, d2y_i;

	assign slot_free = !out_valid_q || pop;
	assign load      = (state_q == ST_IDLE) && q_valid;
	assign step      = (state_q == ST_RUN) && slot_free;
	assign at_last   = (cnt_q == last_idx_q);
	assign q_rd      = load;
	assign empty     = !out_valid_q;
	assign vertex    = out_q;

	// Initial differences at step 1/2^depth
	always_comb begin
		sh1   = SH_W'(q_job.depth);
		sh2   = sh1 << 1;
		sh3   = sh2 + sh1;
		a6x   = (SW'(q_job.ax) <<< 2) + (SW'(q_job.ax) <<< 1);
		a6y   = (SW'(q_job.ay) <<< 2) + (SW'(q_job.ay) <<< 1);
		px_i  = SW'(q_job.x0) <<< sh3;
		py_i  = SW'(q_job.y0) <<< sh3;
		d1x_i = SW'(q_job.ax) + (SW'(q_job.bx) <<< sh1) + (SW'(q_job.cx) <<< sh2);
		d1y_i = SW'(q_job.ay) + (SW'(q_job.by) <<< sh1) + (SW'(q_job.cy) <<< sh2);
		d2x_i = a6x + (SW'(q_job.bx) <<< (sh1 + SH_W'(1)));
		d2y_i = a6y + (SW'(q_job.by) <<< (sh1 + SH_W'(1)));
	end

	assign px_n = px_q + d1x_q;
	assign py_n = py_q + d1y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (load)
						state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (step && at_last)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (step)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			px_q       <= px_i;
			py_q       <= py_i;
			d1x_q      <= d1x_i;
			d1y_q      <= d1y_i;
			d2x_q      <= d2x_i;
			d2y_q      <= d2y_i;
			d3x_q      <= a6x;
			d3y_q      <= a6y;
			sh3_q      <= sh3;
			cnt_q      <= '0;
			last_idx_q <= (CNT_W'(1) << q_job.depth) - CNT_W'(1);
		end else if (step) begin
			px_q  <= px_n;
			py_q  <= py_n;
			d1x_q <= d1x_q + d2x_q;
			d1y_q <= d1y_q + d2y_q;
			d2x_q <= d2x_q + d3x_q;
			d2y_q <= d2y_q + d3y_q;
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (step) begin
			// Arithmetic shift floors back to 4 fractional bits
			out_q.pt_x <= cbf_pkg::COORD_W'(px_n >>> sh3_q);
			out_q.pt_y <= cbf_pkg::COORD_W'(py_n >>> sh3_q);
			out_q.last <= at_last;
		end
	end

endmodule

`default_nettype wire

[rtl/core/cubic_bezier_flattener_core.sv]
// Top level of the cubic Bezier flattener: front end, job queue, back end.
// Uses cbf_pkg, cbf_front, cbf_queue and cbf_back.
`default_nettype none

// A curve pushed in comes out as 2^depth polyline vertices, depth 1 to
// MAX_DEPTH, the final one flagged with last and equal to the end point.
// The front end measures each curve across its pipeline, then hands it to a
// two-entry queue; the back end takes one curve at a time, loads it and then
// produces one vertex per cycle while its output register is free or popped.
// That vertex walk sets the sustained rate; the front end keeps accepting
// curves while the walk runs, until the queue and the front stages fill.
// A waiting vertex does not stop the front end.
module cubic_bezier_flattener_core #(
	parameter int MAX_DEPTH = cbf_pkg::MAX_DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire cbf_pkg::curve_t curve,
	output logic                 empty,
	input  wire logic            pop,
	output cbf_pkg::vertex_t     vertex
);

	logic          q_wr;
	logic          q_full;
	logic          q_rd;
	logic          q_valid;
	cbf_pkg::job_t wr_job;
	cbf_pkg::job_t rd_job;

	cbf_front #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.curve  (curve),
		.q_wr   (q_wr),
		.q_job  (wr_job),
		.q_full (q_full)
	);

	cbf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wr_job (wr_job),
		.full   (q_full),
		.rd     (q_rd),
		.rd_job (rd_job),
		.valid  (q_valid)
	);

	cbf_back #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_job   (rd_job),
		.q_rd    (q_rd),
		.empty   (empty),
		.pop     (pop),
		.vertex  (vertex)
	);

endmodule

`default_nettype wire

[rtl/core/cbf_checker.sv]
// Port-level checks for the flattener core, bound to the top level.
// Uses cbf_pkg for the vertex type and depth limit.
`default_nettype none

module cbf_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             push,
	input wire logic             full,
	input wire logic             empty,
	input wire logic             pop,
	input wire cbf_pkg::vertex_t vertex
);

	// Two front stages, two queue slots, the back end and a trailing vertex
	localparam int CAP   = cbf_pkg::QUEUE_DEPTH + 4;
	localparam int VC_W  = cbf_pkg::MAX_DEPTH_DEF + 1;

	logic [3:0]      inflight_q;
	logic [VC_W-1:0] vcnt_q;
	logic            acc;
	logic            done;

	assign acc  = push && !full;
	assign done = pop && !empty && vertex.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
			vcnt_q     <= '0;
		end else begin
			if (acc && !done)
				inflight_q <= inflight_q + 4'd1;
			else if (done && !acc)
				inflight_q <= inflight_q - 4'd1;
			if (pop && !empty)
				vcnt_q <= vertex.last ? '0 : vcnt_q + VC_W'(1);
		end
	end

	a_no_orphan_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> inflight_q != 4'd0)
		else $error("vertex shown with no curve in flight");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 4'(CAP))
		else $error("more curves held than the core can store");

	a_power_of_two: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($onehot({1'b0, vcnt_q} + (VC_W+1)'(1)) && vcnt_q != '0))
		else $error("curve ended after a vertex count that is not 2^depth");

	a_hold_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(vertex)))
		else $error("waiting vertex changed or vanished");

endmodule

bind cubic_bezier_flattener_core cbf_checker u_cbf_checker (.*);

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for cubic_bezier_flattener_core: curves in, polyline vertices out.
// Depends on cbf_pkg (curve_t, vertex_t, widths) and the core RTL; stands alone otherwise.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_W       = cbf_pkg::COORD_W;
	localparam int MAX_DEPTH_DEF = cbf_pkg::MAX_DEPTH_DEF;
	localparam int HI         = 524287;
	localparam int LO         = -524288;
	localparam int N_DIRECTED = 16;
	localparam int N_FLOOD    = 12;
	localparam int N_RANDOM   = 442;
	localparam int HOLD_LONG  = 600;
	localparam int DRAIN      = 150;
	localparam longint LIMIT  = 2000000;

	typedef struct {
		cbf_pkg::curve_t  c;
		bit               typed;
		cbf_pkg::vertex_t first;
		cbf_pkg::vertex_t second;
	} stim_row_t;

	logic             clk;
	logic             arst_n;
	logic             push;
	logic             full;
	cbf_pkg::curve_t  curve;
	logic             empty;
	logic             pop;
	cbf_pkg::vertex_t vertex;

	// typed expectations travel with the curve so they change at the same edge
	logic             row_typed;
	cbf_pkg::vertex_t row_first;
	cbf_pkg::vertex_t row_second;

	cbf_pkg::vertex_t vertices_due[$];
	stim_row_t stim_rows[N_DIRECTED];
	int        depth_seen[1:6] = '{default: 0};
	int        curves_in = 0;
	int        vertices_out = 0;
	int        mismatches = 0;
	longint    cycle_count = 0;
	bit        flood;

	cubic_bezier_flattener_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.curve  (curve),
		.empty  (empty),
		.pop    (pop),
		.vertex (vertex)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// 2*max + min of the magnitudes, in 1/64 pixel
	function automatic longint octagonal(longint dx, longint dy);
		longint ax;
		longint ay;
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		return ax > ay ? 2 * ax + ay : 2 * ay + ax;
	endfunction

	// Each vertex is P(i/2^depth) evaluated exactly, then floored to 4 fractional bits.
	function automatic void flatten_curve(cbf_pkg::curve_t c);
		longint  p[8];
		longint  sx;
		longint  sy;
		longint  d1;
		longint  d2;
		longint  whole;
		longint  num_x;
		longint  num_y;
		longint  w0;
		longint  w1;
		longint  w2;
		longint  w3;
		int      lg;
		int      depth;
		int      n;
		int      j;
		cbf_pkg::vertex_t v;
		p[0] = longint'(c.x_start);
		p[1] = longint'(c.y_start);
		p[2] = longint'(c.x_ctrl_a);
		p[3] = longint'(c.y_ctrl_a);
		p[4] = longint'(c.x_ctrl_b);
		p[5] = longint'(c.y_ctrl_b);
		p[6] = longint'(c.x_end);
		p[7] = longint'(c.y_end);
		sx = p[0] + p[6];
		sy = p[1] + p[7];
		d1 = octagonal(sx - 2 * p[2], sy - 2 * p[3]);
		d2 = octagonal(sx - 2 * p[4], sy - 2 * p[5]);
		whole = ((d1 > d2 ? d1 : d2) + 63) >>> 6;
		lg = 0;
		while (whole > 1) begin
			whole = whole >>> 1;
			lg++;
		end
		depth = lg / 2 + 1;
		if (depth > MAX_DEPTH_DEF)
			depth = MAX_DEPTH_DEF;
		depth_seen[depth]++;
		n = 1 << depth;
		for (int i = 1; i <= n; i++) begin
			j = n - i;
			w0 = longint'(j * j * j);
			w1 = 3 * longint'(j * j * i);
			w2 = 3 * longint'(j * i * i);
			w3 = longint'(i * i * i);
			num_x = w0 * p[0] + w1 * p[2] + w2 * p[4] + w3 * p[6];
			num_y = w0 * p[1] + w1 * p[3] + w2 * p[5] + w3 * p[7];
			v.pt_x = COORD_W'(num_x >>> (3 * depth));
			v.pt_y = COORD_W'(num_y >>> (3 * depth));
			v.last = (i == n);
			vertices_due.push_back(v);
		end
	endfunction

	function automatic cbf_pkg::curve_t mk_curve(int x0, int y0, int x1, int y1,
			int x2, int y2, int x3, int y3);
		cbf_pkg::curve_t c;
		c.x_start  = COORD_W'(x0);
		c.y_start  = COORD_W'(y0);
		c.x_ctrl_a = COORD_W'(x1);
		c.y_ctrl_a = COORD_W'(y1);
		c.x_ctrl_b = COORD_W'(x2);
		c.y_ctrl_b = COORD_W'(y2);
		c.x_end    = COORD_W'(x3);
		c.y_end    = COORD_W'(y3);
		return c;
	endfunction

	function automatic int clip20(int v);
		return v > HI ? HI : (v < LO ? LO : v);
	endfunction

	function automatic int bulge(int k);
		int m;
		m = int'($urandom_range(0, (1 << k) - 1));
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	// Mostly chords with control points up to a random power of two away from the midpoint,
	// so every depth turns up; the rest are raw bit patterns.
	function automatic cbf_pkg::curve_t random_curve();
		int x0;
		int y0;
		int x3;
		int y3;
		int mx;
		int my;
		int k;
		if ($urandom_range(0, 4) == 0)
			return mk_curve($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom);
		x0 = int'($urandom_range(0, 1048575)) + LO;
		y0 = int'($urandom_range(0, 1048575)) + LO;
		k  = $urandom_range(0, 19);
		x3 = clip20(x0 + bulge(k));
		y3 = clip20(y0 + bulge(k));
		mx = (x0 + x3) / 2;
		my = (y0 + y3) / 2;
		k  = $urandom_range(0, 17);
		return mk_curve(x0, y0, clip20(mx + bulge(k)), clip20(my + bulge(k)),
			clip20(mx + bulge(k)), clip20(my + bulge(k)), x3, y3);
	endfunction

	task automatic send_curve(cbf_pkg::curve_t c, bit typed, cbf_pkg::vertex_t v0,
			cbf_pkg::vertex_t v1, int gap);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push       <= 1'b1;
		curve      <= c;
		row_typed  <= typed;
		row_first  <= v0;
		row_second <= v1;
		do @(posedge clk); while (full);
	endtask

	// Checker: predict on every accepted curve, compare every accepted vertex.
	always @(posedge clk) begin : watch
		cbf_pkg::vertex_t want;
		if (arst_n) begin
			if (push && !full) begin
				curves_in++;
				if (row_typed) begin
					depth_seen[1]++;
					vertices_due.push_back(row_first);
					vertices_due.push_back(row_second);
				end else begin
					flatten_curve(curve);
				end
			end
			if (pop && !empty) begin
				vertices_out++;
				if (vertices_due.size() == 0) begin
					$error("vertex with nothing expected: pt_x %0d pt_y %0d last %0d",
						vertex.pt_x, vertex.pt_y, vertex.last);
					mismatches++;
				end else begin
					want = vertices_due.pop_front();
					if (vertex.pt_x !== want.pt_x) begin
						$error("pt_x: expected %0d, got %0d", want.pt_x, vertex.pt_x);
						mismatches++;
					end
					if (vertex.pt_y !== want.pt_y) begin
						$error("pt_y: expected %0d, got %0d", want.pt_y, vertex.pt_y);
						mismatches++;
					end
					if (vertex.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, vertex.last);
						mismatches++;
					end
				end
			end
		end
	end

	// Receiver: random stall before each vertex, calm stretches, one long hold-off.
	initial begin : drain_side
		int  stall;
		int  taken;
		bit  held;
		taken = 0;
		held  = 1'b0;
		pop   = 1'b0;
		@(posedge arst_n);
		forever begin
			if (flood && !held) begin
				held  = 1'b1;
				stall = HOLD_LONG;
			end else if ((taken % 200) < 40) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, 14);
			end
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			taken++;
		end
	end

	initial begin : feed_side
		cbf_pkg::vertex_t none;
		int      gap;
		none        = '0;
		push        = 1'b0;
		curve       = '0;
		row_typed   = 1'b0;
		row_first   = '0;
		row_second  = '0;
		arst_n      = 1'b0;
		flood       = 1'b0;

		// degenerate points and the rounding of half pixels are typed in
		stim_rows[0]  = '{mk_curve(0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			'{COORD_W'(0), COORD_W'(0), 1'b0}, '{COORD_W'(0), COORD_W'(0), 1'b1}};
		stim_rows[1]  = '{mk_curve(HI, HI, HI, HI, HI, HI, HI, HI), 1'b1,
			'{COORD_W'(HI), COORD_W'(HI), 1'b0}, '{COORD_W'(HI), COORD_W'(HI), 1'b1}};
		stim_rows[2]  = '{mk_curve(LO, LO, LO, LO, LO, LO, LO, LO), 1'b1,
			'{COORD_W'(LO), COORD_W'(LO), 1'b0}, '{COORD_W'(LO), COORD_W'(LO), 1'b1}};
		stim_rows[3]  = '{mk_curve(0, 0, 0, 0, 16, 16, 16, 16), 1'b1,
			'{COORD_W'(8), COORD_W'(8), 1'b0}, '{COORD_W'(16), COORD_W'(16), 1'b1}};
		stim_rows[4]  = '{mk_curve(0, 0, 0, 0, -1, -1, -1, -1), 1'b1,
			'{COORD_W'(-1), COORD_W'(-1), 1'b0}, '{COORD_W'(-1), COORD_W'(-1), 1'b1}};
		stim_rows[5]  = '{mk_curve(0, 0, 0, 0, 1, 1, 1, 1), 1'b1,
			'{COORD_W'(0), COORD_W'(0), 1'b0}, '{COORD_W'(1), COORD_W'(1), 1'b1}};
		// depth steps, equal deltas, second control point dominating, clamp
		stim_rows[6]  = '{mk_curve(0, 0, 47, 0, 0, 0, 0, 0), 1'b0, none, none};
		stim_rows[7]  = '{mk_curve(0, 0, 64, 0, 0, 0, 0, 0), 1'b0, none, none};
		stim_rows[8]  = '{mk_curve(0, 0, 640, 640, 0, 0, 0, 0), 1'b0, none, none};
		stim_rows[9]  = '{mk_curve(0, 0, 1024, 0, 0, 0, 0, 0), 1'b0, none, none};
		stim_rows[10] = '{mk_curve(0, 0, 0, 0, 0, -4096, 0, 0), 1'b0, none, none};
		stim_rows[11] = '{mk_curve(0, 0, 16384, 0, 0, 0, 0, 0), 1'b0, none, none};
		stim_rows[12] = '{mk_curve(LO, LO, HI, HI, LO, LO, HI, HI), 1'b0, none, none};
		stim_rows[13] = '{mk_curve(LO, HI, HI, LO, LO, HI, HI, LO), 1'b0, none, none};
		stim_rows[14] = '{mk_curve(HI, LO, LO, LO, HI, HI, LO, HI), 1'b0, none, none};
		stim_rows[15] = '{mk_curve(-7, 5, -300, 77, 1000, -3, -9, -1), 1'b0, none, none};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[r])
			send_curve(stim_rows[r].c, stim_rows[r].typed, stim_rows[r].first,
				stim_rows[r].second, $urandom_range(0, 14));

		// back-to-back curves while the receiver holds off: fill the block
		flood = 1'b1;
		for (int k = 0; k < N_FLOOD; k++)
			send_curve(random_curve(), 1'b0, none, none, 0);

		for (int k = 0; k < N_RANDOM; k++) begin
			gap = ((k % 50) < 10) ? 0 : $urandom_range(0, 14);
			send_curve(random_curve(), 1'b0, none, none, gap);
		end
		push <= 1'b0;

		while (vertices_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Flattened %0d curves into %0d vertices, %0d mismatches.",
			curves_in, vertices_out, mismatches);
		$display("Curves per depth 1..6: %0d %0d %0d %0d %0d %0d", depth_seen[1],
			depth_seen[2], depth_seen[3], depth_seen[4], depth_seen[5], depth_seen[6]);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[sim.f]
rtl/core/cbf_pkg.sv
rtl/core/cbf_front.sv
rtl/core/cbf_queue.sv
rtl/core/cbf_back.sv
rtl/core/cubic_bezier_flattener_core.sv
rtl/core/cbf_checker.sv
dv/testbench.sv
